>>> design/tlr_pkg.sv
package tlr_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned CordicW     = 36;
  localparam int unsigned LenW        = 31;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CntW        = 5;

  typedef enum logic [CfgIdxW-1:0] {
    RegLengthA = 1'b0,
    RegLengthB = 1'b1
  } cfg_reg_e;

  localparam logic signed [CordicW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [CordicW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CordicW-1:0] KinvQ30   = 36'sd652032874;
  localparam logic signed [CordicW-1:0] Q30One    = 36'sd1073741824;

  // (1e-6)^2 in Q60; any entry of magnitude 1074 or more already exceeds it
  localparam logic [22:0]        SingBoundSq = 23'd1152922;
  localparam logic signed [31:0] SingLim     = 32'sd1074;

  typedef struct packed {
    logic signed [31:0] rot_xx;
    logic signed [31:0] rot_yx;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic               singular;
    logic               zero_t;
  } item_t;

  function automatic logic signed [CordicW-1:0] atan_step(input logic [CntW-1:0] i);
    logic signed [CordicW-1:0] r;
    case (i)
      5'd0:    r = 36'sd843314857;
      5'd1:    r = 36'sd497837830;
      5'd2:    r = 36'sd263043837;
      5'd3:    r = 36'sd133525159;
      5'd4:    r = 36'sd67021687;
      5'd5:    r = 36'sd33543515;
      5'd6:    r = 36'sd16775851;
      5'd7:    r = 36'sd8388438;
      5'd8:    r = 36'sd4194283;
      5'd9:    r = 36'sd2097149;
      5'd10:   r = 36'sd1048576;
      5'd11:   r = 36'sd524288;
      5'd31:   r = '0;
      default: r = CordicW'(1) << (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

>>> design/tlr_in_if.sv
interface tlr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_xx;
  logic signed [31:0] rot_yx;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (output valid, rot_xx, rot_yx, trans_x, trans_y, trans_z, input ready);
  modport sink (input valid, rot_xx, rot_yx, trans_x, trans_y, trans_z, output ready);
endinterface

>>> design/tlr_out_if.sv
interface tlr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] residual;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] grad_z;
  logic signed [31:0] grad_yaw;
  logic               yaw_singular;
  logic               grads_held;

  modport source (output valid, residual, grad_x, grad_y, grad_z, grad_yaw, yaw_singular,
                  grads_held, input ready);
  modport sink (input valid, residual, grad_x, grad_y, grad_z, grad_yaw, yaw_singular,
                grads_held, output ready);
endinterface

>>> design/tlr_front.sv
module tlr_front (
  tlr_in_if.sink          item_i,
  input  logic            full_i,
  output logic            push_o,
  output tlr_pkg::item_t  item_o
);

  logic        xx_small;
  logic        yx_small;
  logic [31:0] xx_abs;
  logic [31:0] yx_abs;
  logic [10:0] xx_mag;
  logic [10:0] yx_mag;
  logic [22:0] mag2;

  assign xx_small = (item_i.rot_xx > -tlr_pkg::SingLim) && (item_i.rot_xx < tlr_pkg::SingLim);
  assign yx_small = (item_i.rot_yx > -tlr_pkg::SingLim) && (item_i.rot_yx < tlr_pkg::SingLim);
  assign xx_abs   = tlr_pkg::abs32(item_i.rot_xx);
  assign yx_abs   = tlr_pkg::abs32(item_i.rot_yx);
  assign xx_mag   = xx_abs[10:0];
  assign yx_mag   = yx_abs[10:0];
  assign mag2     = 23'(xx_mag * xx_mag) + 23'(yx_mag * yx_mag);

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  always_comb begin
    item_o.rot_xx   = item_i.rot_xx;
    item_o.rot_yx   = item_i.rot_yx;
    item_o.trans_x  = item_i.trans_x;
    item_o.trans_y  = item_i.trans_y;
    item_o.trans_z  = item_i.trans_z;
    item_o.singular = xx_small && yx_small && (mag2 < tlr_pkg::SingBoundSq);
    item_o.zero_t   = (item_i.trans_x == '0) && (item_i.trans_y == '0) &&
                      (item_i.trans_z == '0);
  end

endmodule

>>> design/tlr_queue.sv
module tlr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlr_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tlr_pkg::item_t item_o
);

  tlr_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 |=> count_q != 2'd3) else $error("queue overflow");
`endif

endmodule

>>> design/tlr_back.sv
module tlr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tlr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tlr_pkg::LenW-1:0]        cfg_data_i,
  input  logic                            q_valid_i,
  input  tlr_pkg::item_t                  q_item_i,
  output logic                            q_pop_o,
  tlr_out_if.source                       res_o
);

  localparam int unsigned W = tlr_pkg::CordicW;
  localparam logic [tlr_pkg::CntW-1:0] LastStep = tlr_pkg::CntW'(tlr_pkg::CordicSteps - 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ATAN = 10'b0000000010,
    S_PREP = 10'b0000000100,
    S_ROT  = 10'b0000001000,
    S_CS   = 10'b0000010000,
    S_MUL  = 10'b0000100000,
    S_SQRT = 10'b0001000000,
    S_DSET = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic signed [31:0] residual;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic signed [31:0] grad_yaw;
    logic               yaw_singular;
    logic               grads_held;
  } result_t;

  state_e                      state_q, state_d;
  logic [tlr_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [tlr_pkg::LenW-1:0]    len_a_q, len_b_q;
  tlr_pkg::item_t              item_q, item_d;
  logic signed [W-1:0]         cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic                        neg_q, neg_d;
  logic signed [31:0]          cos_q, cos_d, sin_q, sin_d;
  logic [63:0]                 p_q, p_d;
  logic [63:0]                 ab_q, ab_d, msq_q, msq_d, t2_q, t2_d, num_q, num_d;
  logic [63:0]                 sn_q [2];
  logic [63:0]                 sn_d [2];
  logic [33:0]                 sr_q [2];
  logic [33:0]                 sr_d [2];
  logic [31:0]                 root_q [2];
  logic [31:0]                 root_d [2];
  logic [31:0]                 dv_rem_q [4];
  logic [31:0]                 dv_rem_d [4];
  logic [30:0]                 dv_nlo_q [4];
  logic [30:0]                 dv_nlo_d [4];
  logic [30:0]                 dv_quo_q [4];
  logic [30:0]                 dv_quo_d [4];
  logic                        yovf_q, yovf_d;
  logic signed [31:0]          held_q [4];
  logic signed [31:0]          held_d [4];
  logic                        out_valid_q, out_valid_d;
  result_t                     res_q, res_d;

  // shared CORDIC iteration
  logic                        pos;
  logic signed [W-1:0]         xs, ys, at;
  logic signed [W-1:0]         xin, yin, xf, yf;

  // shared multiplier operands
  logic [31:0]                 ma, mb, dab, cc, abs_s;
  logic [31:0]                 tabs [3];
  logic [31:0]                 den [4];
  logic [35:0]                 sq_t;
  logic [35:0]                 sq_trial;
  logic [32:0]                 dv_t;

  // result assembly
  logic signed [32:0]          diff;
  logic signed [31:0]          gnew [4];
  logic [31:0]                 qy;
  logic                        load;

  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  assign at = tlr_pkg::atan_step(cnt_q);
  assign pos = (state_q == S_ATAN) ? cy_q[W-1] : !cz_q[W-1];

  assign xin = W'(q_item_i.rot_xx);
  assign yin = W'(q_item_i.rot_yx);
  assign xf  = neg_q ? -cx_q : cx_q;
  assign yf  = neg_q ? -cy_q : cy_q;

  assign dab     = {1'b0, (len_a_q > len_b_q) ? (len_a_q - len_b_q) : (len_b_q - len_a_q)};
  assign cc      = 32'(tlr_pkg::Q30One - W'(cos_q));
  assign abs_s   = tlr_pkg::abs32(sin_q);
  assign tabs[0] = tlr_pkg::abs32(item_q.trans_x);
  assign tabs[1] = tlr_pkg::abs32(item_q.trans_y);
  assign tabs[2] = tlr_pkg::abs32(item_q.trans_z);
  assign den[0]  = root_q[1];
  assign den[1]  = root_q[1];
  assign den[2]  = root_q[1];
  assign den[3]  = root_q[0];

  always_comb begin
    case (cnt_q)
      5'd0:    begin ma = {1'b0, len_a_q}; mb = {1'b0, len_b_q}; end
      5'd1:    begin ma = dab;             mb = dab;             end
      5'd2:    begin ma = tabs[0];         mb = tabs[0];         end
      5'd3:    begin ma = tabs[1];         mb = tabs[1];         end
      5'd4:    begin ma = tabs[2];         mb = tabs[2];         end
      5'd5:    begin ma = ab_q[63:32];     mb = cc;              end
      5'd6:    begin ma = ab_q[31:0];      mb = cc;              end
      5'd7:    begin ma = ab_q[63:32];     mb = abs_s;           end
      5'd8:    begin ma = ab_q[31:0];      mb = abs_s;           end
      default: begin ma = '0;              mb = '0;              end
    endcase
  end

  assign p_d = ma * mb;

  // result fields
  always_comb begin
    diff = $signed({1'b0, root_q[0]}) - $signed({1'b0, root_q[1]});
    if (diff > 33'sd2147483647) begin
      res_d.residual = 32'sh7fffffff;
    end else if (diff < -33'sd2147483648) begin
      res_d.residual = 32'sh80000000;
    end else begin
      res_d.residual = diff[31:0];
    end
    gnew[0] = item_q.trans_x[31] ? {1'b0, dv_quo_q[0]} : -{1'b0, dv_quo_q[0]};
    gnew[1] = item_q.trans_y[31] ? {1'b0, dv_quo_q[1]} : -{1'b0, dv_quo_q[1]};
    gnew[2] = item_q.trans_z[31] ? {1'b0, dv_quo_q[2]} : -{1'b0, dv_quo_q[2]};
    qy = yovf_q ? 32'h80000000 : {1'b0, dv_quo_q[3]};
    if (root_q[0] == '0) begin
      gnew[3] = '0;
    end else if (sin_q[31]) begin
      gnew[3] = -qy;
    end else begin
      gnew[3] = qy[31] ? 32'sh7fffffff : qy;
    end
    for (int k = 0; k < 4; k++) begin
      held_d[k] = item_q.zero_t ? held_q[k] : gnew[k];
    end
    res_d.grad_x       = held_d[0];
    res_d.grad_y       = held_d[1];
    res_d.grad_z       = held_d[2];
    res_d.grad_yaw     = held_d[3];
    res_d.yaw_singular = item_q.singular;
    res_d.grads_held   = item_q.zero_t;
  end

  assign load    = (state_q == S_DONE) && (!out_valid_q || res_o.ready);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + 5'd1;
    item_d      = item_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    neg_d       = neg_q;
    cos_d       = cos_q;
    sin_d       = sin_q;
    ab_d        = ab_q;
    msq_d       = msq_q;
    t2_d        = t2_q;
    num_d       = num_q;
    yovf_d      = yovf_q;
    sn_d        = sn_q;
    sr_d        = sr_q;
    root_d      = root_q;
    dv_rem_d    = dv_rem_q;
    dv_nlo_d    = dv_nlo_q;
    dv_quo_d    = dv_quo_q;
    sq_t        = '0;
    sq_trial    = '0;
    dv_t        = '0;
    out_valid_d = load ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (q_valid_i) begin
          item_d = q_item_i;
          if (q_item_i.singular) begin
            cos_d   = 32'sh40000000;
            sin_d   = '0;
            state_d = S_MUL;
          end else begin
            cx_d = q_item_i.rot_xx[31] ? -xin : xin;
            cy_d = q_item_i.rot_xx[31] ? -yin : yin;
            if (!q_item_i.rot_xx[31]) begin
              cz_d = '0;
            end else begin
              cz_d = q_item_i.rot_yx[31] ? -tlr_pkg::PiQ30 : tlr_pkg::PiQ30;
            end
            state_d = S_ATAN;
          end
        end
      end
      S_ATAN, S_ROT: begin
        if (pos) begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - at;
        end else begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + at;
        end
        if (cnt_q == LastStep) begin
          state_d = (state_q == S_ATAN) ? S_PREP : S_CS;
        end
      end
      S_PREP: begin
        cnt_d = '0;
        cx_d  = tlr_pkg::KinvQ30;
        cy_d  = '0;
        if (cz_q > tlr_pkg::HalfPiQ30) begin
          cz_d  = cz_q - tlr_pkg::PiQ30;
          neg_d = 1'b1;
        end else if (cz_q < -tlr_pkg::HalfPiQ30) begin
          cz_d  = cz_q + tlr_pkg::PiQ30;
          neg_d = 1'b1;
        end else begin
          neg_d = 1'b0;
        end
        state_d = S_ROT;
      end
      S_CS: begin
        cnt_d = '0;
        if (xf > tlr_pkg::Q30One) begin
          cos_d = 32'sh40000000;
        end else if (xf < -tlr_pkg::Q30One) begin
          cos_d = 32'shc0000000;
        end else begin
          cos_d = xf[31:0];
        end
        if (yf > tlr_pkg::Q30One) begin
          sin_d = 32'sh40000000;
        end else if (yf < -tlr_pkg::Q30One) begin
          sin_d = 32'shc0000000;
        end else begin
          sin_d = yf[31:0];
        end
        state_d = S_MUL;
      end
      S_MUL: begin
        // p_q holds the registered product issued at the previous count
        case (cnt_q)
          5'd1:    ab_d  = p_q;
          5'd2:    msq_d = p_q;
          5'd3:    t2_d  = p_q;
          5'd4:    t2_d  = t2_q + p_q;
          5'd5:    t2_d  = t2_q + p_q;
          5'd6:    msq_d = msq_q + (p_q << 3);
          5'd7:    msq_d = msq_q + (p_q >> 29);
          5'd8:    num_d = p_q << 2;
          5'd9:    num_d = num_q + (p_q >> 30);
          default: num_d = num_q;
        endcase
        if (cnt_q == 5'd9) begin
          cnt_d     = '0;
          sn_d[0]   = msq_q;
          sn_d[1]   = t2_q;
          sr_d[0]   = '0;
          sr_d[1]   = '0;
          root_d[0] = '0;
          root_d[1] = '0;
          state_d   = S_SQRT;
        end
      end
      S_SQRT: begin
        for (int k = 0; k < 2; k++) begin
          sq_t     = {sr_q[k], sn_q[k][63:62]};
          sq_trial = {2'b00, root_q[k], 2'b01};
          if (sq_t >= sq_trial) begin
            sr_d[k]   = 34'(sq_t - sq_trial);
            root_d[k] = {root_q[k][30:0], 1'b1};
          end else begin
            sr_d[k]   = sq_t[33:0];
            root_d[k] = {root_q[k][30:0], 1'b0};
          end
          sn_d[k] = sn_q[k] << 2;
        end
        if (cnt_q == 5'd31) begin
          state_d = S_DSET;
        end
      end
      S_DSET: begin
        cnt_d = '0;
        for (int k = 0; k < 3; k++) begin
          dv_rem_d[k] = {1'b0, tabs[k][31:1]};
          dv_nlo_d[k] = {tabs[k][0], 30'd0};
          dv_quo_d[k] = '0;
        end
        dv_rem_d[3] = num_q[62:31];
        dv_nlo_d[3] = num_q[30:0];
        dv_quo_d[3] = '0;
        yovf_d      = num_q[63:31] >= {1'b0, root_q[0]};
        state_d     = S_DIV;
      end
      S_DIV: begin
        for (int k = 0; k < 4; k++) begin
          dv_t = {dv_rem_q[k], dv_nlo_q[k][30]};
          if (dv_t >= {1'b0, den[k]}) begin
            dv_rem_d[k] = 32'(dv_t - {1'b0, den[k]});
            dv_quo_d[k] = {dv_quo_q[k][29:0], 1'b1};
          end else begin
            dv_rem_d[k] = dv_t[31:0];
            dv_quo_d[k] = {dv_quo_q[k][29:0], 1'b0};
          end
          dv_nlo_d[k] = dv_nlo_q[k] << 1;
        end
        if (cnt_q == 5'd30) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      len_a_q     <= '0;
      len_b_q     <= '0;
      for (int k = 0; k < 4; k++) begin
        held_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tlr_pkg::RegLengthA: len_a_q <= cfg_data_i;
          tlr_pkg::RegLengthB: len_b_q <= cfg_data_i;
          default:             len_a_q <= len_a_q;
        endcase
      end
      if (load) begin
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cz_q     <= cz_d;
    neg_q    <= neg_d;
    cos_q    <= cos_d;
    sin_q    <= sin_d;
    p_q      <= p_d;
    ab_q     <= ab_d;
    msq_q    <= msq_d;
    t2_q     <= t2_d;
    num_q    <= num_d;
    yovf_q   <= yovf_d;
    sn_q     <= sn_d;
    sr_q     <= sr_d;
    root_q   <= root_d;
    dv_rem_q <= dv_rem_d;
    dv_nlo_q <= dv_nlo_d;
    dv_quo_q <= dv_quo_d;
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.residual     = res_q.residual;
  assign res_o.grad_x       = res_q.grad_x;
  assign res_o.grad_y       = res_q.grad_y;
  assign res_o.grad_z       = res_q.grad_z;
  assign res_o.grad_yaw     = res_q.grad_yaw;
  assign res_o.yaw_singular = res_q.yaw_singular;
  assign res_o.grads_held   = res_q.grads_held;

`ifndef SYNTHESIS
  a_held_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.grad_x == held_q[0]) && (res_q.grad_yaw == held_q[3]))
    else $error("beat gradients differ from held gradients");
  a_singular_yaw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.yaw_singular && !res_q.grads_held |-> res_q.grad_yaw == '0)
    else $error("nonzero yaw gradient on singular rotation");
  a_unit_grad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.grad_x <= 32'sh40000000) && (res_q.grad_x >= 32'shc0000000))
    else $error("unit gradient out of range");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q != S_IDLE))
    else $error("pop without starting work");
`endif

endmodule

>>> design/tether_length_residual_unit.sv
// Each accepted item goes through the atan and sin/cos CORDIC passes, the multiplies, the root pair
// and the divider bank before its result beat; a singular rotation skips both CORDIC passes.
// The back end takes one item at a time and holds its result while the output stalls; the two
// CORDIC passes, the 32-step root pair and the 31-step divider bank share one sequencer.
// A two-entry queue and a result register let beats proceed while the back end is busy.
// Reset (rst_ni, async low) clears lengths, held gradients and all handshake state.
module tether_length_residual_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tlr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tlr_pkg::LenW-1:0]    cfg_data_i,
  tlr_in_if.sink                      item_i,
  tlr_out_if.source                   res_o
);

  logic           full;
  logic           push;
  logic           q_valid;
  logic           q_pop;
  tlr_pkg::item_t front_item;
  tlr_pkg::item_t q_item;

  tlr_front u_front (
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  tlr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  tlr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .res_o      (res_o)
  );

endmodule

>>> tb/tb_tether_length_residual_unit.sv
`timescale 1ns / 100ps

module tb_tether_length_residual_unit;

  localparam longint Q30 = 64'sd1073741824;
  localparam longint PI_Q = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint KINV_Q = 64'sd652032874;
  localparam int     STEPS = tlr_pkg::CordicSteps;

  typedef struct {
    logic signed [31:0] rot_xx;
    logic signed [31:0] rot_yx;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } pose_t;

  typedef struct {
    logic signed [31:0] residual;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic signed [31:0] grad_yaw;
    logic               yaw_singular;
    logic               grads_held;
  } resid_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tlr_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [tlr_pkg::LenW-1:0] cfg_data_i;

  tlr_in_if  in_if ();
  tlr_out_if out_if ();

  tether_length_residual_unit u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .item_i    (in_if),
    .res_o     (out_if)
  );

  // predictor state
  longint unsigned len_a, len_b;
  logic signed [31:0] hold_gx = '0, hold_gy = '0, hold_gz = '0, hold_gyaw = '0;

  pose_t  pose_q[$];
  resid_t resid_q[$];
  int     mismatches = 0;
  bit     beat_taken;
  int     burst_left = 0, gap_left = 0;
  int     rdy_mode, rdy_left = 0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint angle_step(int i);
    longint tab[12] = '{843314857, 497837830, 263043837, 133525159, 67021687, 33543515,
                        16775851, 8388438, 4194283, 2097149, 1048576, 524288};
    if (i < 12) return tab[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint yaw_atan2(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q : -PI_Q;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + asr64(y, i); ny = y - asr64(x, i); z += angle_step(i);
      end else begin
        nx = x - asr64(y, i); ny = y + asr64(x, i); z -= angle_step(i);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  task automatic yaw_sincos(input longint zin, output longint c, output longint s);
    longint x, y, z, nx, ny;
    bit neg;
    x = KINV_Q; y = 0; z = zin; neg = 0;
    if (z > HALF_PI_Q) begin
      z -= PI_Q; neg = 1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q; neg = 1;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - asr64(y, i); ny = y + asr64(x, i); z -= angle_step(i);
      end else begin
        nx = x + asr64(y, i); ny = y - asr64(x, i); z += angle_step(i);
      end
      x = nx;
      y = ny;
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = clamp(x, -Q30, Q30);
    s = clamp(y, -Q30, Q30);
  endtask

  function automatic logic signed [31:0] unit_dir(longint v, longint unsigned d);
    longint q;
    q = (-v * Q30) / longint'(d);
    return 32'(clamp(q, -Q30, Q30));
  endfunction

  task automatic predict_residual(input pose_t p, output resid_t r);
    longint rxx, ryx, tx, ty, tz, c, s, g, diff;
    longint unsigned mag2, ab, dab, msq, m, d, t2, num, q, abs_s;
    logic [127:0] wide;
    bit sing;
    rxx = p.rot_xx; ryx = p.rot_yx;
    tx = p.trans_x; ty = p.trans_y; tz = p.trans_z;
    mag2 = longint'(rxx * rxx) + longint'(ryx * ryx);
    sing = mag2 < 64'd1152922;
    if (sing) begin
      c = Q30; s = 0;
    end else begin
      yaw_sincos(yaw_atan2(ryx, rxx), c, s);
    end
    ab = len_a * len_b;
    dab = len_a > len_b ? len_a - len_b : len_b - len_a;
    wide = 128'(ab) * 128'(Q30 - c);
    msq = dab * dab + 64'(wide >> 29);
    m = floor_sqrt(msq);
    t2 = longint'(tx * tx) + longint'(ty * ty) + longint'(tz * tz);
    d = floor_sqrt(t2);
    diff = longint'(m) - longint'(d);
    r.residual = 32'(clamp(diff, -64'sd2147483648, 64'sd2147483647));
    if (d != 0) begin
      hold_gx = unit_dir(tx, d);
      hold_gy = unit_dir(ty, d);
      hold_gz = unit_dir(tz, d);
      if (m == 0) begin
        hold_gyaw = 0;
      end else begin
        abs_s = s < 0 ? -s : s;
        wide = 128'(ab) * 128'(abs_s);
        num = 64'(wide >> 30);
        q = num / m;
        g = q > 64'd2147483648 ? 64'sd2147483648 : longint'(q);
        if (s < 0) g = -g;
        hold_gyaw = 32'(clamp(g, -64'sd2147483648, 64'sd2147483647));
      end
    end
    r.grad_x = hold_gx;
    r.grad_y = hold_gy;
    r.grad_z = hold_gz;
    r.grad_yaw = hold_gyaw;
    r.yaw_singular = sing;
    r.grads_held = (d == 0);
  endtask

  // input beats and result beats
  always @(posedge clk_i) begin
    resid_t e;
    beat_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      predict_residual(pose_q.pop_front(), e);
      resid_q.push_back(e);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (resid_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        e = resid_q.pop_front();
        if (out_if.residual !== e.residual || out_if.grad_x !== e.grad_x ||
            out_if.grad_y !== e.grad_y || out_if.grad_z !== e.grad_z ||
            out_if.grad_yaw !== e.grad_yaw || out_if.yaw_singular !== e.yaw_singular ||
            out_if.grads_held !== e.grads_held) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp res=%0d g=%0d/%0d/%0d yaw=%0d s=%0b h=%0b",
                     $realtime, e.residual, e.grad_x, e.grad_y, e.grad_z, e.grad_yaw,
                     e.yaw_singular, e.grads_held);
            $display("                 got res=%0d g=%0d/%0d/%0d yaw=%0d s=%0b h=%0b",
                     out_if.residual, out_if.grad_x, out_if.grad_y, out_if.grad_z,
                     out_if.grad_yaw, out_if.yaw_singular, out_if.grads_held);
          end
        end
      end
    end
  end

  // sender: bursts with gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || beat_taken) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 6);
      end
      if (gap_left > 0 || pose_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.rot_xx <= pose_q[0].rot_xx;
        in_if.rot_yx <= pose_q[0].rot_yx;
        in_if.trans_x <= pose_q[0].trans_x;
        in_if.trans_y <= pose_q[0].trans_y;
        in_if.trans_z <= pose_q[0].trans_z;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(20, 400);
    end
    rdy_left--;
    case (rdy_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= $urandom_range(0, 1);
      2: out_if.ready <= ($urandom_range(0, 7) == 0);
      default: out_if.ready <= (rdy_left % 5) != 0;
    endcase
  end

  function automatic logic signed [31:0] rand_rot();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2200) - 1100;
      1: return 32'($urandom_range(0, 1) ? Q30 : -Q30);
      2: return 0;
      default: return $urandom_range(0, 32'h8000_0000) - 32'sh4000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_len_comp();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 2000) - 1000;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_pose(input logic signed [31:0] xx, yx, tx, ty, tz);
    pose_t p;
    p.rot_xx = xx; p.rot_yx = yx; p.trans_x = tx; p.trans_y = ty; p.trans_z = tz;
    pose_q.push_back(p);
  endtask

  task automatic add_random(input int n);
    pose_t p;
    for (int i = 0; i < n; i++) begin
      p.rot_xx = rand_rot();
      p.rot_yx = rand_rot();
      if ($urandom_range(0, 9) == 0) begin
        p.trans_x = 0; p.trans_y = 0; p.trans_z = 0;
      end else begin
        p.trans_x = rand_len_comp();
        p.trans_y = rand_len_comp();
        p.trans_z = rand_len_comp();
      end
      pose_q.push_back(p);
    end
  endtask

  task automatic drain();
    while (pose_q.size() != 0 || resid_q.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic set_lengths(input logic [tlr_pkg::LenW-1:0] a,
                             input logic [tlr_pkg::LenW-1:0] b);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= tlr_pkg::RegLengthA; cfg_data_i <= a;
    @(negedge clk_i);
    cfg_idx_i <= tlr_pkg::RegLengthB; cfg_data_i <= b;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    len_a = a;
    len_b = b;
  endtask

  function automatic logic [tlr_pkg::LenW-1:0] rand_len();
    case ($urandom_range(0, 5))
      0: return tlr_pkg::LenW'($urandom_range(0, 32'h0004_0000));
      1: return {tlr_pkg::LenW{1'b1}};
      default: return tlr_pkg::LenW'($urandom());
    endcase
  endfunction

  initial begin
    logic [tlr_pkg::LenW-1:0] la;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = tlr_pkg::RegLengthA; cfg_data_i = '0;
    len_a = 0; len_b = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // lengths at reset value: zero distance, held gradients at reset
    add_pose(Q30, 0, 0, 0, 0);
    add_pose(Q30, 0, 32'sh0001_0000, 0, 0);
    add_pose(0, 0, 0, 0, 0);
    drain();

    set_lengths(32'h0001_0000, 32'h0002_0000);
    add_pose(Q30, 0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    add_pose(-Q30, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    add_pose(0, Q30, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_pose(0, -Q30, 1, -1, 0);
    add_pose(-Q30, -1, 0, 0, 0);
    add_pose(-Q30, 0, 0, 0, -5);
    add_pose(1073, 0, 100, 200, 300);
    add_pose(1074, 0, 100, 200, 300);
    add_pose(-1000, 400, 0, 0, 0);
    add_pose(32'sh2d41_3ccc, -32'sh2d41_3ccc, -32'sh1234_5678, 7, 32'sh0000_ffff);
    drain();

    set_lengths({tlr_pkg::LenW{1'b1}}, {tlr_pkg::LenW{1'b1}});
    add_pose(Q30, 0, 32'sh0100_0000, 0, 0);
    add_pose(-Q30, 0, 32'sh0100_0000, 0, 0);
    add_pose(0, Q30, 0, 32'sh7fff_ffff, 0);
    add_pose(0, -Q30, 0, 0, 32'sh8000_0000);
    add_pose(-Q30, Q30, 0, 0, 0);
    drain();

    set_lengths({tlr_pkg::LenW{1'b1}}, '0);
    add_pose(Q30, Q30, 3, 4, 12);
    add_pose(-Q30, -Q30, -3, -4, -12);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      la = rand_len();
      set_lengths(la, ($urandom_range(0, 4) == 0) ? la : rand_len());
      add_random(160);
      drain();
    end

    if (mismatches == 0 && resid_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
design/tlr_pkg.sv
design/tlr_in_if.sv
design/tlr_out_if.sv
design/tlr_front.sv
design/tlr_queue.sv
design/tlr_back.sv
design/tether_length_residual_unit.sv
tb/tb_tether_length_residual_unit.sv
